// ----- sv/hrlc_pkg.sv -----
// ----------------------------------------------------------------------------
// hrlc_pkg
// Types, byte codes and name tables of the request line checker.
// ----------------------------------------------------------------------------
package hrlc_pkg;

  localparam logic [7:0] ByteNul      = 8'h00;
  localparam logic [7:0] ByteLf       = 8'h0A;
  localparam logic [7:0] ByteCr       = 8'h0D;
  localparam logic [7:0] ByteSpace    = 8'h20;
  localparam logic [7:0] ByteQuestion = 8'h3F;

  localparam int unsigned NumMethods = 8;
  localparam logic [3:0]  PosMax     = 4'd15;
  localparam logic [3:0]  VersionLen = 4'd8;

  localparam logic [7:0] MethodName [NumMethods][8] = '{
    '{"g", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"p", "o", "s", "t", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"p", "u", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"d", "e", "l", "e", "t", "e", 8'h00, 8'h00},
    '{"c", "o", "n", "n", "e", "c", "t", 8'h00},
    '{"t", "r", "a", "c", "e", 8'h00, 8'h00, 8'h00},
    '{"h", "e", "a", "d", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"o", "p", "t", "i", "o", "n", "s", 8'h00}
  };

  localparam logic [3:0] MethodLen [NumMethods] = '{
    4'd3, 4'd4, 4'd3, 4'd6, 4'd7, 4'd5, 4'd4, 4'd7
  };

  localparam logic [7:0] VersionText [8] = '{"h", "t", "t", "p", "/", "1", ".", "1"};

  typedef enum logic [4:0] {
    PH_METHOD        = 5'b00001,
    PH_TARGET_FIRST  = 5'b00010,
    PH_TARGET        = 5'b00100,
    PH_VERSION_FIRST = 5'b01000,
    PH_VERSION       = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    VERDICT_OK      = 2'd0,
    VERDICT_BAD     = 2'd1,
    VERDICT_VERSION = 2'd2
  } verdict_e;

  typedef enum logic {
    KIND_TARGET  = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e      item_kind;
    logic [7:0] target_byte;
    logic       in_query;
    verdict_e   verdict;
    logic [2:0] method_code;
    logic       last_item;
  } result_t;

  function automatic logic [7:0] fold(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'd65 && b <= 8'd90) begin
      r = b + 8'd32;
    end
    return r;
  endfunction

endpackage

// ----- sv/hrlc_if.sv -----
// ----------------------------------------------------------------------------
// hrlc_if
// Valid/ready channels for request bytes and for result items.
// ----------------------------------------------------------------------------
interface hrlc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_request;

  modport source (output valid, output data_byte, output start_of_request, input ready);
  modport sink (input valid, input data_byte, input start_of_request, output ready);
endinterface

interface hrlc_out_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] target_byte;
  logic       in_query;
  logic [1:0] verdict;
  logic [2:0] method_code;
  logic       last_item;

  modport source (output valid, output item_kind, output target_byte, output in_query,
                  output verdict, output method_code, output last_item, input ready);
  modport sink (input valid, input item_kind, input target_byte, input in_query,
                input verdict, input method_code, input last_item, output ready);
endinterface

// ----- sv/http_request_line_checker.sv -----
// ----------------------------------------------------------------------------
// http_request_line_checker
// Checks an HTTP request line byte by byte, passes target bytes, gives a verdict.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                             kind
//  in_i     in   data_byte, start_of_request                         valid/ready
//  out_o    out  item_kind, target_byte, in_query, verdict,          valid/ready
//                method_code, last_item
//
//  one item per cycle sustained while out_o does not stall
//  an input register and a result register frame the parser step
//  in_i stays ready while the input register moves on or is empty
//  rst_ni clears the parser to the method phase and empties both registers
//  a stalled out_o holds its item and backs up into in_i
// ----------------------------------------------------------------------------
module http_request_line_checker (
  input  logic     clk_i,
  input  logic     rst_ni,
  hrlc_in_if.sink  in_i,
  hrlc_out_if.source out_o
);

  logic              s_valid_q;
  logic [7:0]        s_byte_q;
  logic              s_start_q;
  logic              out_valid_q, out_valid_d;
  hrlc_pkg::result_t out_q;
  logic              advance;
  logic              res_valid;
  hrlc_pkg::result_t res;

  assign advance    = s_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s_byte_q  <= in_i.data_byte;
      s_start_q <= in_i.start_of_request;
    end
  end

  hrlc_parser u_parser (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (advance),
    .data_byte_i        (s_byte_q),
    .start_of_request_i (s_start_q),
    .res_valid_o        (res_valid),
    .res_o              (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res_valid;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.item_kind   = out_q.item_kind;
  assign out_o.target_byte = out_q.target_byte;
  assign out_o.in_query    = out_q.in_query;
  assign out_o.verdict     = out_q.verdict;
  assign out_o.method_code = out_q.method_code;
  assign out_o.last_item   = out_q.last_item;

  ap_not_ready_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> s_valid_q && out_valid_q && !out_o.ready)
    else $error("input stalled without a full pipeline");

  ap_verdict_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.item_kind == hrlc_pkg::KIND_VERDICT |-> out_o.last_item
      && out_o.target_byte == 8'h00 && !out_o.in_query)
    else $error("verdict item fields wrong");

  ap_target_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.item_kind == hrlc_pkg::KIND_TARGET |-> !out_o.last_item
      && out_o.verdict == hrlc_pkg::VERDICT_OK && out_o.method_code == 3'd0)
    else $error("target item fields wrong");

  ap_failed_no_method: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.verdict != hrlc_pkg::VERDICT_OK |-> out_o.method_code == 3'd0)
    else $error("method code on failing verdict");

endmodule

// ----- sv/hrlc_parser.sv -----
// ----------------------------------------------------------------------------
// hrlc_parser
// Parser state and the per-byte step that yields at most one result item.
// ----------------------------------------------------------------------------
module hrlc_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          data_byte_i,
  input  logic                start_of_request_i,
  output logic                res_valid_o,
  output hrlc_pkg::result_t   res_o
);

  hrlc_pkg::phase_e phase_q, phase_d, phase_c;
  logic [3:0] pos_q, pos_d, pos_c;
  logic [7:0] cand_q, cand_d, cand_c;
  logic       vmatch_q, vmatch_d, vmatch_c;
  logic       cr_q, cr_d, cr_c;
  logic       query_q, query_d, query_c;
  logic       given_q, given_d, given_c;

  logic [7:0] folded;
  logic [7:0] hit;
  logic [2:0] code;
  logic       do_bad, do_pass, do_version, do_finish;

  assign folded = hrlc_pkg::fold(data_byte_i);

  // start of request clears the parser before the byte is used
  always_comb begin
    if (start_of_request_i) begin
      phase_c  = hrlc_pkg::PH_METHOD;
      pos_c    = '0;
      cand_c   = '1;
      vmatch_c = 1'b1;
      cr_c     = 1'b0;
      query_c  = 1'b0;
      given_c  = 1'b0;
    end else begin
      phase_c  = phase_q;
      pos_c    = pos_q;
      cand_c   = cand_q;
      vmatch_c = vmatch_q;
      cr_c     = cr_q;
      query_c  = query_q;
      given_c  = given_q;
    end
  end

  always_comb begin
    hit = '0;
    for (int k = hrlc_pkg::NumMethods - 1; k >= 0; k--) begin
      if (cand_c[k] && hrlc_pkg::MethodLen[k] == pos_c) begin
        hit = 8'(1 << k);
      end
    end
  end

  always_comb begin
    code = '0;
    for (int k = hrlc_pkg::NumMethods - 1; k >= 0; k--) begin
      if (cand_d[k]) begin
        code = 3'(k);
      end
    end
  end

  always_comb begin
    phase_d     = phase_c;
    pos_d       = pos_c;
    cand_d      = cand_c;
    vmatch_d    = vmatch_c;
    cr_d        = cr_c;
    query_d     = query_c;
    given_d     = given_c;
    do_bad      = 1'b0;
    do_pass     = 1'b0;
    do_version  = 1'b0;
    do_finish   = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (!given_c) begin
      unique case (phase_c)
        hrlc_pkg::PH_METHOD: begin
          if (data_byte_i == hrlc_pkg::ByteNul) begin
            do_bad = 1'b1;
          end else if (data_byte_i == hrlc_pkg::ByteSpace) begin
            if (hit == '0) begin
              do_bad = 1'b1;
            end else begin
              cand_d  = hit;
              pos_d   = '0;
              phase_d = hrlc_pkg::PH_TARGET_FIRST;
            end
          end else begin
            for (int k = 0; k < hrlc_pkg::NumMethods; k++) begin
              if (pos_c >= hrlc_pkg::MethodLen[k] ||
                  folded != hrlc_pkg::MethodName[k][pos_c[2:0]]) begin
                cand_d[k] = 1'b0;
              end
            end
            if (pos_c != hrlc_pkg::PosMax) begin
              pos_d = pos_c + 4'd1;
            end
          end
        end
        hrlc_pkg::PH_TARGET_FIRST: begin
          if (data_byte_i == hrlc_pkg::ByteNul || data_byte_i == hrlc_pkg::ByteSpace) begin
            do_bad = 1'b1;
          end else begin
            phase_d = hrlc_pkg::PH_TARGET;
            do_pass = 1'b1;
          end
        end
        hrlc_pkg::PH_TARGET: begin
          if (data_byte_i == hrlc_pkg::ByteNul) begin
            do_bad = 1'b1;
          end else if (data_byte_i == hrlc_pkg::ByteSpace) begin
            phase_d  = hrlc_pkg::PH_VERSION_FIRST;
            pos_d    = '0;
            vmatch_d = 1'b1;
            cr_d     = 1'b0;
          end else begin
            do_pass = 1'b1;
          end
        end
        hrlc_pkg::PH_VERSION_FIRST: begin
          if (data_byte_i == hrlc_pkg::ByteNul || data_byte_i == hrlc_pkg::ByteSpace) begin
            do_bad = 1'b1;
          end else begin
            phase_d    = hrlc_pkg::PH_VERSION;
            do_version = 1'b1;
          end
        end
        hrlc_pkg::PH_VERSION: begin
          if (cr_c) begin
            if (data_byte_i == hrlc_pkg::ByteLf) begin
              do_finish = 1'b1;
            end else begin
              do_bad = 1'b1;
            end
          end else begin
            do_version = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (do_version) begin
      priority if (data_byte_i == hrlc_pkg::ByteNul) begin
        do_bad = 1'b1;
      end else if (data_byte_i == hrlc_pkg::ByteCr) begin
        cr_d = 1'b1;
      end else if (data_byte_i == hrlc_pkg::ByteLf) begin
        do_finish = 1'b1;
      end else begin
        if (pos_c >= hrlc_pkg::VersionLen ||
            folded != hrlc_pkg::VersionText[pos_c[2:0]]) begin
          vmatch_d = 1'b0;
        end
        if (pos_c != hrlc_pkg::PosMax) begin
          pos_d = pos_c + 4'd1;
        end
      end
    end

    if (do_bad) begin
      given_d           = 1'b1;
      res_valid_o       = 1'b1;
      res_o.item_kind   = hrlc_pkg::KIND_VERDICT;
      res_o.verdict     = hrlc_pkg::VERDICT_BAD;
      res_o.last_item   = 1'b1;
    end else if (do_finish) begin
      given_d           = 1'b1;
      res_valid_o       = 1'b1;
      res_o.item_kind   = hrlc_pkg::KIND_VERDICT;
      res_o.last_item   = 1'b1;
      if (vmatch_c && pos_c == hrlc_pkg::VersionLen) begin
        res_o.verdict     = hrlc_pkg::VERDICT_OK;
        res_o.method_code = code;
      end else begin
        res_o.verdict     = hrlc_pkg::VERDICT_VERSION;
      end
    end else if (do_pass) begin
      // first question mark only opens the query
      if (data_byte_i == hrlc_pkg::ByteQuestion && !query_c) begin
        query_d = 1'b1;
      end else begin
        res_valid_o       = 1'b1;
        res_o.item_kind   = hrlc_pkg::KIND_TARGET;
        res_o.target_byte = data_byte_i;
        res_o.in_query    = query_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= hrlc_pkg::PH_METHOD;
      pos_q    <= '0;
      cand_q   <= '1;
      vmatch_q <= 1'b1;
      cr_q     <= 1'b0;
      query_q  <= 1'b0;
      given_q  <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      cand_q   <= cand_d;
      vmatch_q <= vmatch_d;
      cr_q     <= cr_d;
      query_q  <= query_d;
      given_q  <= given_d;
    end
  end

  ap_cand_onehot_after_method: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != hrlc_pkg::PH_METHOD |-> $onehot(cand_q))
    else $error("method candidates not one-hot after method");

  ap_no_result_after_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    given_q && !start_of_request_i |-> !res_valid_o)
    else $error("result after verdict");

  ap_verdict_closes_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && res_o.item_kind == hrlc_pkg::KIND_VERDICT |=> given_q)
    else $error("verdict did not close the request");

endmodule
